/* hw/rtl/b2b_pkg.sv */
// ----------------------------------------------------------------------------
// BLAKE2b engine package
// Constants, types and helper functions shared by the engine's modules.
// ----------------------------------------------------------------------------
package b2b_pkg;

    localparam int DLEN_W = 7;
    localparam logic [DLEN_W-1:0] DLEN_RESET = 7'd10;
    localparam int QDEPTH = 2;

    localparam logic [63:0] IV0 = 64'h6a09e667f3bcc908;
    localparam logic [63:0] IV1 = 64'hbb67ae8584caa73b;
    localparam logic [63:0] IV2 = 64'h3c6ef372fe94f82b;
    localparam logic [63:0] IV3 = 64'ha54ff53a5f1d36f1;
    localparam logic [63:0] IV4 = 64'h510e527fade682d1;
    localparam logic [63:0] IV5 = 64'h9b05688c2b3e6c1f;
    localparam logic [63:0] IV6 = 64'h1f83d9abfb41bd6b;
    localparam logic [63:0] IV7 = 64'h5be0cd19137e2179;
    localparam logic [63:0] PARAM_BASE = 64'h0000000001010000;

    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic        last;
    } item_t;

    function automatic logic [63:0] iv_word(input logic [2:0] i);
        logic [63:0] r;
        begin
            case (i)
                3'd0: r = IV0;
                3'd1: r = IV1;
                3'd2: r = IV2;
                3'd3: r = IV3;
                3'd4: r = IV4;
                3'd5: r = IV5;
                3'd6: r = IV6;
                default: r = IV7;
            endcase
            return r;
        end
    endfunction

    function automatic logic [6:0] eff_len(input logic [DLEN_W-1:0] l);
        logic [6:0] r;
        begin
            r = l;
            if (l == 7'd0) r = 7'd1;
            if (l > 7'd64) r = 7'd64;
            return r;
        end
    endfunction

    function automatic logic [3:0] sigma(input logic [3:0] r, input logic [3:0] j);
        logic [63:0] row;
        begin
            case (r)
                4'd0: row = 64'hfedcba9876543210;
                4'd1: row = 64'h357b20c16df984ae;
                4'd2: row = 64'h491763eadf250c8b;
                4'd3: row = 64'h8f04a562ebcd1397;
                4'd4: row = 64'hd386cb1efa427509;
                4'd5: row = 64'h91ef57d438b0a6c2;
                4'd6: row = 64'hb8293670a4def15c;
                4'd7: row = 64'ha2684f05931ce7bd;
                4'd8: row = 64'h5a417d2c803b9ef6;
                default: row = 64'h0dc3e9bf5167482a;
            endcase
            return row[{j, 2'b00} +: 4];
        end
    endfunction

endpackage

/* hw/rtl/blake2b_hash_engine_core.sv */
// ----------------------------------------------------------------------------
// BLAKE2b hash engine
// Unkeyed BLAKE2b over a stream of little-endian message words.
// ----------------------------------------------------------------------------
// Usage: message words enter on the s_ stream; tdata carries the word in
// bits 63:0 and its valid byte count in bits 67:64, and tlast marks the
// final word. A two-entry request queue decouples input from compression.
// Bytes are packed one per cycle, pausing while a full block is compressed.
// Each 128-byte block is compressed one G function per cycle (96 steps plus
// setup and feed-forward).
// After the final word the digest appears on the m_ stream as up to eight
// words, one per cycle while m_tready is high; tlast marks the final word.
// A stalled receiver holds the current digest word and halts the engine.
// cfg_we with cfg_wdata sets the digest length (1 to 64 bytes) and drops any
// message in progress. Reset sets the length to 10 and clears the queue and hash state.
module blake2b_hash_engine_core #(
    parameter int QDepth = b2b_pkg::QDEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [b2b_pkg::DLEN_W-1:0]    cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [71:0]                   s_tdata,   // message_word, word_bytes, zero fill
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [71:0]                   m_tdata,   // digest_word, digest_word_bytes, zero fill
    output logic                          m_tlast
);
    logic q_valid, q_pop;
    b2b_pkg::item_t q_item;

    b2b_front #(.QDepth(QDepth)) u_front (
        .aclk(aclk), .aresetn(aresetn), .flush(cfg_we),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tlast(s_tlast), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
    );

    b2b_back u_back (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );
endmodule

/* hw/rtl/b2b_front.sv */
// ----------------------------------------------------------------------------
// BLAKE2b input front
// Accepts message words and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module b2b_front #(
    parameter int QDepth = b2b_pkg::QDEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                flush,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [71:0]         s_tdata,
    input  logic                s_tlast,
    output logic                q_valid,
    input  logic                q_pop,
    output b2b_pkg::item_t      q_item
);
    localparam int AW = (QDepth > 1) ? $clog2(QDepth) : 1;

    b2b_pkg::item_t mem_reg [QDepth];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic push;
    b2b_pkg::item_t in_item;

    always_comb begin
        in_item.word   = s_tdata[63:0];
        in_item.nbytes = (s_tdata[67:64] > 4'd8) ? 4'd8 : s_tdata[67:64];
        in_item.last   = s_tlast;
    end

    assign s_tready = (cnt_reg != (AW+1)'(QDepth));
    assign push = s_tvalid && s_tready;
    assign q_valid = (cnt_reg != '0);
    assign q_item = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= in_item;
        end
        if (!aresetn || flush) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= (wp_reg == AW'(QDepth-1)) ? '0 : wp_reg + 1'b1;
            if (q_pop) rp_reg <= (rp_reg == AW'(QDepth-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(q_pop);
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= (AW+1)'(QDepth)) else $error("queue overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid) else $error("pop from empty queue");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0) |-> (wp_reg == rp_reg)) else $error("pointer mismatch");
endmodule

/* hw/rtl/b2b_back.sv */
// ----------------------------------------------------------------------------
// BLAKE2b compression back end
// Packs bytes into the block, runs the compression one G step per cycle and
// emits the digest words.
// ----------------------------------------------------------------------------
module b2b_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [b2b_pkg::DLEN_W-1:0]    cfg_wdata,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  b2b_pkg::item_t                q_item,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [71:0]                   m_tdata,
    output logic                          m_tlast
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PACK = 5'b00010,
        S_INIT = 5'b00100,
        S_G    = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t state_reg;
    logic [b2b_pkg::DLEN_W-1:0] dlen_reg;
    logic [63:0] h_reg [8];
    logic [63:0] m_reg [16];
    logic [63:0] v_reg [16];
    logic [7:0]  fill_reg;
    logic [63:0] cnt_reg;
    b2b_pkg::item_t cur_reg;
    logic [3:0]  bi_reg;
    logic        fin_reg;
    logic [3:0]  rnd_reg;
    logic [3:0]  rsig_reg;
    logic [2:0]  gi_reg;
    logic [2:0]  k_reg;
    logic        ovalid_reg;
    logic [71:0] odata_reg;
    logic        olast_reg;

    logic [6:0] len;
    logic [6:0] init_len;
    logic [3:0] a, b, c, d;
    logic [63:0] x, y, va, vb, vc, vd;
    logic [63:0] a1, d1, c1, b1, a2, d2, c2, b2;
    logic [63:0] hk;
    logic [6:0] rem;
    logic [3:0] nb;
    logic       emit;

    assign len = b2b_pkg::eff_len(dlen_reg);
    assign init_len = b2b_pkg::eff_len(aresetn ? cfg_wdata : b2b_pkg::DLEN_RESET);

    always_comb begin
        case (gi_reg)
            3'd0: begin a = 4'd0; b = 4'd4; c = 4'd8;  d = 4'd12; end
            3'd1: begin a = 4'd1; b = 4'd5; c = 4'd9;  d = 4'd13; end
            3'd2: begin a = 4'd2; b = 4'd6; c = 4'd10; d = 4'd14; end
            3'd3: begin a = 4'd3; b = 4'd7; c = 4'd11; d = 4'd15; end
            3'd4: begin a = 4'd0; b = 4'd5; c = 4'd10; d = 4'd15; end
            3'd5: begin a = 4'd1; b = 4'd6; c = 4'd11; d = 4'd12; end
            3'd6: begin a = 4'd2; b = 4'd7; c = 4'd8;  d = 4'd13; end
            default: begin a = 4'd3; b = 4'd4; c = 4'd9; d = 4'd14; end
        endcase
        x = m_reg[b2b_pkg::sigma(rsig_reg, {gi_reg, 1'b0})];
        y = m_reg[b2b_pkg::sigma(rsig_reg, {gi_reg, 1'b1})];
        va = v_reg[a]; vb = v_reg[b]; vc = v_reg[c]; vd = v_reg[d];
        a1 = va + vb + x;
        d1 = {vd[31:0] ^ a1[31:0], vd[63:32] ^ a1[63:32]};
        c1 = vc + d1;
        b1 = ((vb ^ c1) >> 24) | ((vb ^ c1) << 40);
        a2 = a1 + b1 + y;
        d2 = ((d1 ^ a2) >> 16) | ((d1 ^ a2) << 48);
        c2 = c1 + d2;
        b2 = ((b1 ^ c2) >> 63) | ((b1 ^ c2) << 1);
        rem = len - {1'b0, k_reg, 3'b000};
        nb = (rem > 7'd8) ? 4'd8 : rem[3:0];
        hk = h_reg[k_reg];
    end

    assign q_pop = (state_reg == S_IDLE) && q_valid;
    assign emit = (state_reg == S_OUT) && (rnd_reg == 4'd0) && (!ovalid_reg || m_tready);
    assign m_tvalid = ovalid_reg;
    assign m_tdata = odata_reg;
    assign m_tlast = olast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_we) begin
            state_reg <= S_IDLE;
            ovalid_reg <= 1'b0;
            if (!aresetn) dlen_reg <= b2b_pkg::DLEN_RESET;
            else dlen_reg <= cfg_wdata;
            for (int i = 0; i < 8; i++)
                h_reg[i] <= (i == 0)
                    ? (b2b_pkg::IV0 ^ b2b_pkg::PARAM_BASE ^ 64'(init_len))
                    : b2b_pkg::iv_word(3'(i));
            for (int i = 0; i < 16; i++) m_reg[i] <= '0;
            fill_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (emit) ovalid_reg <= 1'b1;
            else if (m_tvalid && m_tready) ovalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        cur_reg <= q_item;
                        bi_reg <= '0;
                        state_reg <= S_PACK;
                    end
                end
                S_PACK: begin
                    if (bi_reg < cur_reg.nbytes) begin
                        if (fill_reg[7]) begin
                            fin_reg <= 1'b0;
                            state_reg <= S_INIT;
                        end else begin
                            m_reg[fill_reg[6:3]][{fill_reg[2:0], 3'b000} +: 8]
                                <= cur_reg.word[{bi_reg[2:0], 3'b000} +: 8];
                            fill_reg <= fill_reg + 8'd1;
                            cnt_reg <= cnt_reg + 64'd1;
                            bi_reg <= bi_reg + 4'd1;
                        end
                    end else if (cur_reg.last) begin
                        fin_reg <= 1'b1;
                        state_reg <= S_INIT;
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                S_INIT: begin
                    for (int i = 0; i < 8; i++) begin
                        v_reg[i] <= h_reg[i];
                        if (i == 4)
                            v_reg[i+8] <= b2b_pkg::IV4 ^ cnt_reg;
                        else if (i == 6)
                            v_reg[i+8] <= fin_reg ? ~b2b_pkg::IV6 : b2b_pkg::IV6;
                        else
                            v_reg[i+8] <= b2b_pkg::iv_word(3'(i));
                    end
                    rnd_reg <= '0;
                    rsig_reg <= '0;
                    gi_reg <= '0;
                    state_reg <= S_G;
                end
                S_G: begin
                    v_reg[a] <= a2; v_reg[b] <= b2; v_reg[c] <= c2; v_reg[d] <= d2;
                    gi_reg <= gi_reg + 3'd1;
                    if (gi_reg == 3'd7) begin
                        rnd_reg <= rnd_reg + 4'd1;
                        rsig_reg <= (rsig_reg == 4'd9) ? 4'd0 : rsig_reg + 4'd1;
                        if (rnd_reg == 4'd11) begin
                            state_reg <= S_OUT;
                            k_reg <= '0;
                        end
                    end
                end
                S_OUT: begin
                    if (rnd_reg != 4'd0) begin
                        for (int i = 0; i < 8; i++)
                            h_reg[i] <= h_reg[i] ^ v_reg[i] ^ v_reg[i+8];
                        rnd_reg <= '0;
                        if (!fin_reg) begin
                            for (int i = 0; i < 16; i++) m_reg[i] <= '0;
                            fill_reg <= '0;
                            state_reg <= S_PACK;
                        end
                    end else if (emit) begin
                        odata_reg <= {4'd0, nb,
                            (nb == 4'd8) ? hk : (hk & ((64'd1 << {nb, 3'b000}) - 64'd1))};
                        olast_reg <= (rem <= 7'd8);
                        k_reg <= k_reg + 3'd1;
                        if (rem <= 7'd8) begin
                            for (int i = 0; i < 8; i++)
                                h_reg[i] <= (i == 0)
                                    ? (b2b_pkg::IV0 ^ b2b_pkg::PARAM_BASE ^ 64'(len))
                                    : b2b_pkg::iv_word(3'(i));
                            for (int i = 0; i < 16; i++) m_reg[i] <= '0;
                            fill_reg <= '0;
                            cnt_reg <= '0;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= 8'd128) else $error("block overfill");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready && !cfg_we) |=> m_tvalid) else $error("result dropped");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[67:64] >= 4'd1 && m_tdata[67:64] <= 4'd8))
        else $error("bad digest byte count");
endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// BLAKE2b hash engine testbench
// Streams random and directed messages through the engine across several
// digest lengths, predicts each digest in the testbench and checks every
// digest word, with random gaps, a long output stall and idle pauses.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic        last;
    } digest_t;

    localparam int STALL_LIMIT = 8000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [6:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        m_tlast;

    blake2b_hash_engine_core dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always #2 aclk = ~aclk;

    int unsigned sched [10][16] = '{
        '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15},
        '{14, 10, 4, 8, 9, 15, 13, 6, 1, 12, 0, 2, 11, 7, 5, 3},
        '{11, 8, 12, 0, 5, 2, 15, 13, 10, 14, 3, 6, 7, 1, 9, 4},
        '{7, 9, 3, 1, 13, 12, 11, 14, 2, 6, 5, 10, 4, 0, 15, 8},
        '{9, 0, 5, 7, 2, 4, 10, 15, 14, 1, 11, 12, 6, 8, 3, 13},
        '{2, 12, 6, 10, 0, 11, 8, 3, 4, 13, 7, 5, 15, 14, 1, 9},
        '{12, 5, 1, 15, 14, 13, 4, 10, 0, 7, 6, 3, 9, 2, 8, 11},
        '{13, 11, 7, 14, 12, 1, 3, 9, 5, 0, 15, 4, 8, 6, 2, 10},
        '{6, 15, 14, 9, 11, 3, 0, 8, 12, 2, 13, 7, 1, 4, 10, 5},
        '{10, 2, 8, 4, 7, 6, 1, 5, 15, 11, 9, 14, 3, 12, 13, 0}};

    logic [63:0] chain [8];
    logic [63:0] blk [16];
    int unsigned fill;
    logic [63:0] byte_count;
    logic [6:0]  dlen;

    b2b_pkg::item_t pending_words [$];
    digest_t        expected_digest [$];
    b2b_pkg::item_t cur;
    int      mismatches = 0;
    int      gap = 0;
    int      stall = 0;
    int      idle_cycles = 0;
    bit      jitter_on = 1'b0;
    bit      hold_out = 1'b0;

    function automatic logic [63:0] iv(input int i);
        return b2b_pkg::iv_word(3'(i));
    endfunction

    function automatic logic [63:0] ror(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function automatic int unsigned clamped_len();
        if (dlen == 0) return 1;
        if (dlen > 64) return 64;
        return dlen;
    endfunction

    function automatic void restart_message();
        for (int i = 0; i < 8; i++) chain[i] = iv(i);
        chain[0] ^= b2b_pkg::PARAM_BASE ^ 64'(clamped_len());
        for (int i = 0; i < 16; i++) blk[i] = '0;
        fill = 0;
        byte_count = '0;
    endfunction

    function automatic void compress(input bit final_blk);
        logic [63:0] v [16];
        int          a [8] = '{0, 1, 2, 3, 0, 1, 2, 3};
        int          b [8] = '{4, 5, 6, 7, 5, 6, 7, 4};
        int          c [8] = '{8, 9, 10, 11, 10, 11, 8, 9};
        int          d [8] = '{12, 13, 14, 15, 15, 12, 13, 14};
        for (int i = 0; i < 8; i++) begin
            v[i] = chain[i];
            v[i + 8] = iv(i);
        end
        v[12] ^= byte_count;
        if (final_blk) v[14] = ~v[14];
        for (int r = 0; r < 12; r++) begin
            for (int g = 0; g < 8; g++) begin
                v[a[g]] = v[a[g]] + v[b[g]] + blk[sched[r % 10][2 * g]];
                v[d[g]] = ror(v[d[g]] ^ v[a[g]], 32);
                v[c[g]] = v[c[g]] + v[d[g]];
                v[b[g]] = ror(v[b[g]] ^ v[c[g]], 24);
                v[a[g]] = v[a[g]] + v[b[g]] + blk[sched[r % 10][2 * g + 1]];
                v[d[g]] = ror(v[d[g]] ^ v[a[g]], 16);
                v[c[g]] = v[c[g]] + v[d[g]];
                v[b[g]] = ror(v[b[g]] ^ v[c[g]], 63);
            end
        end
        for (int i = 0; i < 8; i++) chain[i] ^= v[i] ^ v[i + 8];
    endfunction

    function automatic void absorb_word(input b2b_pkg::item_t it);
        int unsigned n;
        int unsigned len;
        int unsigned nb;
        digest_t     dw;
        n = (it.nbytes > 8) ? 8 : it.nbytes;
        for (int i = 0; i < n; i++) begin
            if (fill >= 128) begin
                compress(1'b0);
                for (int j = 0; j < 16; j++) blk[j] = '0;
                fill = 0;
            end
            blk[fill / 8] |= 64'(it.word[8 * i +: 8]) << (8 * (fill % 8));
            fill++;
            byte_count++;
        end
        if (!it.last) return;
        compress(1'b1);
        len = clamped_len();
        for (int k = 0; k < (len + 7) / 8; k++) begin
            nb = (len - 8 * k > 8) ? 8 : len - 8 * k;
            dw.word = chain[k];
            if (nb < 8) dw.word &= (64'd1 << (8 * nb)) - 1;
            dw.nbytes = 4'(nb);
            dw.last = (k + 1 == (len + 7) / 8);
            expected_digest = {expected_digest, dw};
        end
        restart_message();
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) absorb_word(cur);
            if (!s_tvalid || s_tready) begin
                if (gap > 0) begin
                    gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    cur = pending_words.pop_front();
                    s_tdata <= {4'b0, cur.nbytes, cur.word};
                    s_tlast <= cur.last;
                    s_tvalid <= 1'b1;
                    gap = jitter_on ? $urandom_range(0, 17) : 0;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_digest.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected digest word %h", m_tdata[63:0]);
            end else begin
                digest_t e;
                e = expected_digest.pop_front();
                if (m_tdata[63:0] !== e.word || m_tdata[67:64] !== e.nbytes
                        || m_tlast !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("digest mismatch: expected %h/%0d/%b got %h/%0d/%b",
                                 e.word, e.nbytes, e.last,
                                 m_tdata[63:0], m_tdata[67:64], m_tlast);
                end
            end
            stall = jitter_on ? $urandom_range(0, 17) : 0;
        end
        if (stall > 0) begin
            stall--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= !hold_out;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic void queue_word(input logic [63:0] w, input int n, input bit l);
        b2b_pkg::item_t it;
        it.word = w;
        it.nbytes = 4'(n);
        it.last = l;
        pending_words = {pending_words, it};
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic int queue_random_message();
        int nw;
        int nb;
        nw = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 12);
        for (int i = 0; i < nw; i++) begin
            if (i == nw - 1)
                nb = $urandom_range(0, 15);
            else
                nb = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : 8;
            queue_word(rand_word(), nb, i == nw - 1);
        end
        return nw;
    endfunction

    task automatic drain();
        while (pending_words.size() > 0 || s_tvalid || expected_digest.size() > 0)
            @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    task automatic write_length(input logic [6:0] v);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        dlen = v;
        restart_message();
    endtask

    initial begin
        logic [6:0] lengths [8] = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd65, 7'd32, 7'd10, 7'd7};
        int sent;
        dlen = b2b_pkg::DLEN_RESET;
        restart_message();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        queue_word(64'h0, 0, 1'b1);
        queue_word('1, 8, 1'b1);
        queue_word(rand_word(), 15, 1'b1);
        queue_word(rand_word(), 3, 1'b0);
        queue_word(rand_word(), 8, 1'b0);
        queue_word(rand_word(), 0, 1'b1);
        queue_word(64'h0, 0, 1'b0);
        queue_word(rand_word(), 5, 1'b1);
        for (int i = 0; i < 16; i++) queue_word(i[0] ? '1 : 64'h0, 8, 1'b0);
        queue_word(rand_word(), 0, 1'b1);
        drain();

        sent = 0;
        for (int ph = 0; sent < 300; ph++) begin
            write_length(ph < 8 ? lengths[ph] : 7'($urandom_range(0, 127)));
            jitter_on = ($urandom_range(0, 3) != 0);
            if (ph == 2) begin
                jitter_on = 1'b0;
                fork
                    begin
                        hold_out = 1'b1;
                        repeat (600) @(posedge aclk);
                        hold_out = 1'b0;
                    end
                join_none
                for (int m = 0; m < 6; m++) sent += queue_random_message();
            end else begin
                for (int m = 0; m < 3; m++) sent += queue_random_message();
            end
            drain();
        end

        if (mismatches == 0 && expected_digest.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
